[design/flha_pkg.sv]
// ----------------------------------------------------------------------------
// Free list heap allocator package
// Shared datapath operation codes, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package flha_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // Smallest block, in bytes, and the chunk size after reset
  localparam logic [31:0] MIN_BLOCK   = 32'd16;
  localparam logic [16:0] CHUNK_RESET = 17'd4096;

  // Prologue and epilogue tag words
  localparam logic [31:0] TAG_PROLOGUE = 32'd9;
  localparam logic [31:0] TAG_EPILOGUE = 32'd1;

  // Datapath operations, one per controller cycle
  typedef enum logic [5:0] {
    OP_NOP,
    OP_ACC,
    OP_INIT,
    OP_W_PAD,
    OP_W_PRO_H,
    OP_W_PRO_F,
    OP_W_EPI,
    OP_RD_BPM4,
    OP_RD_BPM8,
    OP_RD_PBM4,
    OP_RD_NBM4,
    OP_RD_XP4,
    OP_RD_X,
    OP_RD_BP,
    OP_LD_PB,
    OP_LD_PU,
    OP_LD_SZ,
    OP_LD_NU,
    OP_LD_PRED,
    OP_LD_SUCC,
    OP_LD_NEXT,
    OP_ADD_SZ,
    OP_W_BPM4_SZ,
    OP_W_BPSZM8_SZ,
    OP_W_PBM4_SZ,
    OP_W_PBSZM8_SZ,
    OP_W_BPSZM4_ONE,
    OP_W_BPM4_NEED1,
    OP_W_BPNEEDM8_NEED1,
    OP_W_BPM4_SZ1,
    OP_W_BPSZM8_SZ1,
    OP_SPLIT,
    OP_W_NBM4_SZ,
    OP_W_NBSZM8_SZ,
    OP_W_PRED_SUCC,
    OP_HEAD_SUCC,
    OP_W_SUCCP4_PRED,
    OP_W_XP4_ZERO,
    OP_W_HEADP4_X,
    OP_W_X_HEAD,
    OP_X_BP,
    OP_X_PB,
    OP_X_NB,
    OP_BP_PB,
    OP_GROW_SIZE,
    OP_SET_BRK,
    OP_RES_OK,
    OP_RES_ZERO,
    OP_RES_OOM,
    OP_RES_NONE,
    OP_OUT_LOAD
  } op_t;

  // Command from the controller to the datapath
  typedef struct packed {
    op_t op;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic kind;
    logic req_zero;
    logic bp_zero;
    logic walk_end;
    logic fit;
    logic pu;
    logic nu;
    logic pred_zero;
    logic succ_zero;
    logic head_zero;
    logic grow_ovf;
    logic split_ok;
    logic free_addr_ok;
    logic free_blk_ok;
  } stat_t;

endpackage

[design/free_list_heap_allocator.sv]
// ----------------------------------------------------------------------------
// Free list heap allocator
// First-fit explicit free list allocator with boundary tags and coalescing.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser: kind; tdata: request_bytes[15:0], block_addr[31:16]
//  m_*      | out       | tdata: result_addr[15:0], status[17:16]
//  APB      | cfg       | register 0 at address 0: chunk_bytes
//
// An allocate takes longer for each free list entry passed over, and longer
// again when the heap grows. The single-port heap memory sets this, one word
// per cycle. A stalled output adds its stall. The heap setup after reset ends
// before the first item is taken.
// One item is in work at a time; the next is taken while a result waits.
// ----------------------------------------------------------------------------
module free_list_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes, block_addr
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result_addr, status, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  flha_pkg::cmd_t  cmd;
  flha_pkg::stat_t stat;
  logic [16:0]     chunk;
  logic [15:0]     out_addr;
  logic [1:0]      out_status;
  logic            cfg_we;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {15'd0, chunk} : 32'd0;

  assign m_tdata = {6'd0, out_status, out_addr};

  flha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  flha_dpath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_tuser),
    .in_req     (s_tdata[15:0]),
    .in_addr    (s_tdata[31:16]),
    .cfg_we     (cfg_we),
    .cfg_data   (pwdata[16:0]),
    .chunk      (chunk),
    .out_addr   (out_addr),
    .out_status (out_status)
  );

endmodule

[design/flha_dpath.sv]
// ----------------------------------------------------------------------------
// Allocator datapath
// Heap word memory, block pointer registers and the result registers.
// ----------------------------------------------------------------------------
module flha_dpath #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  flha_pkg::cmd_t   cmd,
  output flha_pkg::stat_t  stat,
  input  logic             in_kind,
  input  logic [15:0]      in_req,
  input  logic [15:0]      in_addr,
  input  logic             cfg_we,
  input  logic [16:0]      cfg_data,
  output logic [16:0]      chunk,
  output logic [15:0]      out_addr,
  output logic [1:0]       out_status
);

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IW         = $clog2(HEAP_WORDS);
  localparam int WALK       = HEAP_BYTES / 16 + 1;
  localparam int CW         = $clog2(WALK + 1);

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] mem_q;
  logic        rd_ok;
  logic [31:0] mdat;

  logic [31:0] bp, pb, nb, sz, x, pred, succ, head, brk;
  logic [16:0] need;
  logic [CW-1:0] cnt;
  logic        kind, req_zero, pu, nu, bu;
  logic [15:0] rs_addr;
  logic [1:0]  rs_status;

  logic [31:0] maddr, mwdata;
  logic        mwe, mre, in_rng;
  logic [IW-1:0] idx;
  logic [16:0] grow_bytes;
  logic [14:0] grow_w;
  logic [17:0] grow_size;
  logic [16:0] need_calc;

  assign mdat   = rd_ok ? mem_q : 32'd0;
  assign in_rng = maddr[31:2] < 30'(HEAP_WORDS);
  assign idx    = maddr[IW+1:2];

  // Request size rounded to whole double words plus tags
  assign need_calc = (in_req <= 16'd8) ? 17'd16 :
                     (({1'b0, in_req} + 17'd15) & ~17'd7);

  // Growth size: larger of need and chunk, cut to words, rounded to even words
  assign grow_bytes = (need > chunk) ? need : chunk;
  assign grow_w     = grow_bytes[16:2];
  assign grow_size  = {({1'b0, grow_w} + {15'd0, grow_w[0]}), 2'b00};

  // Memory address and write data for each operation
  always_comb begin
    maddr  = 32'd0;
    mwdata = 32'd0;
    mwe    = 1'b0;
    mre    = 1'b0;
    case (cmd.op)
      flha_pkg::OP_W_PAD:   begin maddr = 32'd0; mwe = 1'b1; end
      flha_pkg::OP_W_PRO_H: begin
        maddr = 32'd4; mwdata = flha_pkg::TAG_PROLOGUE; mwe = 1'b1;
      end
      flha_pkg::OP_W_PRO_F: begin
        maddr = 32'd8; mwdata = flha_pkg::TAG_PROLOGUE; mwe = 1'b1;
      end
      flha_pkg::OP_W_EPI: begin
        maddr = 32'd12; mwdata = flha_pkg::TAG_EPILOGUE; mwe = 1'b1;
      end
      flha_pkg::OP_RD_BPM4: begin maddr = bp - 32'd4; mre = 1'b1; end
      flha_pkg::OP_RD_BPM8: begin maddr = bp - 32'd8; mre = 1'b1; end
      flha_pkg::OP_RD_PBM4: begin maddr = pb - 32'd4; mre = 1'b1; end
      flha_pkg::OP_RD_NBM4: begin maddr = nb - 32'd4; mre = 1'b1; end
      flha_pkg::OP_RD_XP4:  begin maddr = x + 32'd4;  mre = 1'b1; end
      flha_pkg::OP_RD_X:    begin maddr = x;          mre = 1'b1; end
      flha_pkg::OP_RD_BP:   begin maddr = bp;         mre = 1'b1; end
      flha_pkg::OP_W_BPM4_SZ: begin
        maddr = bp - 32'd4; mwdata = sz; mwe = 1'b1;
      end
      flha_pkg::OP_W_BPSZM8_SZ: begin
        maddr = bp + sz - 32'd8; mwdata = sz; mwe = 1'b1;
      end
      flha_pkg::OP_W_PBM4_SZ: begin
        maddr = pb - 32'd4; mwdata = sz; mwe = 1'b1;
      end
      flha_pkg::OP_W_PBSZM8_SZ: begin
        maddr = pb + sz - 32'd8; mwdata = sz; mwe = 1'b1;
      end
      flha_pkg::OP_W_BPSZM4_ONE: begin
        maddr = bp + sz - 32'd4; mwdata = flha_pkg::TAG_EPILOGUE; mwe = 1'b1;
      end
      flha_pkg::OP_W_BPM4_NEED1: begin
        maddr = bp - 32'd4; mwdata = {15'd0, need} | 32'd1; mwe = 1'b1;
      end
      flha_pkg::OP_W_BPNEEDM8_NEED1: begin
        maddr = bp + {15'd0, need} - 32'd8; mwdata = {15'd0, need} | 32'd1;
        mwe = 1'b1;
      end
      flha_pkg::OP_W_BPM4_SZ1: begin
        maddr = bp - 32'd4; mwdata = sz | 32'd1; mwe = 1'b1;
      end
      flha_pkg::OP_W_BPSZM8_SZ1: begin
        maddr = bp + sz - 32'd8; mwdata = sz | 32'd1; mwe = 1'b1;
      end
      flha_pkg::OP_W_NBM4_SZ: begin
        maddr = nb - 32'd4; mwdata = sz; mwe = 1'b1;
      end
      flha_pkg::OP_W_NBSZM8_SZ: begin
        maddr = nb + sz - 32'd8; mwdata = sz; mwe = 1'b1;
      end
      flha_pkg::OP_W_PRED_SUCC: begin
        maddr = pred; mwdata = succ; mwe = 1'b1;
      end
      flha_pkg::OP_W_SUCCP4_PRED: begin
        maddr = succ + 32'd4; mwdata = pred; mwe = 1'b1;
      end
      flha_pkg::OP_W_XP4_ZERO: begin
        maddr = x + 32'd4; mwe = 1'b1;
      end
      flha_pkg::OP_W_HEADP4_X: begin
        maddr = head + 32'd4; mwdata = x; mwe = 1'b1;
      end
      flha_pkg::OP_W_X_HEAD: begin
        maddr = x; mwdata = head; mwe = 1'b1;
      end
      default: begin
        maddr = 32'd0;
      end
    endcase
  end

  // Heap word memory, one access per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mwe && in_rng) begin
      mem[idx] <= mwdata;
    end
    if (mre) begin
      mem_q <= mem[idx];
      rd_ok <= in_rng;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= flha_pkg::CHUNK_RESET;
    end else if (cfg_we) begin
      chunk <= cfg_data;
    end
  end

  // Pointer, size and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      flha_pkg::OP_ACC: begin
        kind     <= in_kind;
        req_zero <= (in_req == 16'd0);
        need     <= need_calc;
        bp       <= in_kind ? {16'd0, in_addr} : head;
        cnt      <= '0;
      end
      flha_pkg::OP_INIT: begin
        brk  <= 32'd16;
        head <= 32'd0;
        need <= 17'd0;
      end
      flha_pkg::OP_LD_PB:   pb <= bp - (mdat & ~32'd7);
      flha_pkg::OP_LD_PU:   pu <= mdat[0];
      flha_pkg::OP_LD_SZ: begin
        sz <= mdat & ~32'd7;
        bu <= mdat[0];
        nb <= bp + (mdat & ~32'd7);
      end
      flha_pkg::OP_LD_NU:   nu   <= mdat[0];
      flha_pkg::OP_LD_PRED: pred <= mdat;
      flha_pkg::OP_LD_SUCC: succ <= mdat;
      flha_pkg::OP_LD_NEXT: begin
        bp  <= mdat;
        cnt <= cnt + CW'(1);
      end
      flha_pkg::OP_ADD_SZ:  sz <= sz + (mdat & ~32'd7);
      flha_pkg::OP_SPLIT: begin
        nb <= bp + {15'd0, need};
        sz <= sz - {15'd0, need};
      end
      flha_pkg::OP_HEAD_SUCC: head <= succ;
      flha_pkg::OP_W_X_HEAD:  head <= x;
      flha_pkg::OP_X_BP:      x    <= bp;
      flha_pkg::OP_X_PB:      x    <= pb;
      flha_pkg::OP_X_NB:      x    <= nb;
      flha_pkg::OP_BP_PB:     bp   <= pb;
      flha_pkg::OP_GROW_SIZE: begin
        sz <= {14'd0, grow_size};
        bp <= brk;
      end
      flha_pkg::OP_SET_BRK:  brk <= bp + sz;
      flha_pkg::OP_RES_OK: begin
        rs_addr   <= bp[15:0];
        rs_status <= flha_pkg::ST_OK;
      end
      flha_pkg::OP_RES_ZERO: begin
        rs_addr   <= 16'd0;
        rs_status <= flha_pkg::ST_ZERO;
      end
      flha_pkg::OP_RES_OOM: begin
        rs_addr   <= 16'd0;
        rs_status <= flha_pkg::ST_OOM;
      end
      flha_pkg::OP_RES_NONE: begin
        rs_addr   <= 16'd0;
        rs_status <= flha_pkg::ST_OK;
      end
      flha_pkg::OP_OUT_LOAD: begin
        out_addr   <= rs_addr;
        out_status <= rs_status;
      end
      default: begin
      end
    endcase
  end

  // Status flags for the controller
  always_comb begin
    stat.kind         = kind;
    stat.req_zero     = req_zero;
    stat.bp_zero      = (bp == 32'd0);
    stat.walk_end     = (cnt >= CW'(WALK));
    stat.fit          = ({15'd0, need} <= (mdat & ~32'd7)) && !mdat[0];
    stat.pu           = pu;
    stat.nu           = nu;
    stat.pred_zero    = (pred == 32'd0);
    stat.succ_zero    = (succ == 32'd0);
    stat.head_zero    = (head == 32'd0);
    stat.grow_ovf     = ({1'b0, brk} + {1'b0, sz}) > 33'(HEAP_BYTES);
    stat.split_ok     = ({1'b0, sz} >= ({16'd0, need} + {1'b0, flha_pkg::MIN_BLOCK}));
    stat.free_addr_ok = (bp != 32'd0) && (bp[2:0] == 3'd0) && (bp >= 32'd16);
    stat.free_blk_ok  = bu && (sz >= flha_pkg::MIN_BLOCK) &&
                        (({1'b0, bp} + {1'b0, sz}) <= {1'b0, brk});
  end

endmodule

[design/flha_ctrl.sv]
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences heap setup, first-fit search, growth, split, merge and list edits.
// ----------------------------------------------------------------------------
module flha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  flha_pkg::stat_t  stat,
  output flha_pkg::cmd_t   cmd,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready
);

  typedef enum logic [6:0] {
    S_BOOT0, S_BOOT1, S_BOOT2, S_BOOT3, S_BOOT4,
    S_IDLE, S_DISP, S_A0, S_W0, S_W1, S_W2,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_MP,
    S_C1A, S_C1B, S_C1C, S_C1D,
    S_C2A, S_C2B, S_C2C, S_C2D, S_C2E,
    S_C3A, S_C3B, S_C3C, S_C3D, S_C3E,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5,
    S_P0, S_P1, S_P2,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8,
    S_F0, S_F1, S_F2, S_F3, S_FN,
    S_RESOK, S_DONE
  } state_t;

  state_t state, state_next;
  state_t rem_ret, rem_ret_next;
  state_t push_ret, push_ret_next;
  state_t merge_ret, merge_ret_next;
  logic   booting, booting_next;
  logic   m_tvalid_next;
  flha_pkg::op_t op;

  assign cmd.op   = op;
  assign s_tready = (state == S_IDLE);

  // Next state and datapath operation
  always_comb begin
    op             = flha_pkg::OP_NOP;
    state_next     = state;
    rem_ret_next   = rem_ret;
    push_ret_next  = push_ret;
    merge_ret_next = merge_ret;
    booting_next   = booting;
    case (state)
      S_BOOT0: begin op = flha_pkg::OP_W_PAD;   state_next = S_BOOT1; end
      S_BOOT1: begin op = flha_pkg::OP_W_PRO_H; state_next = S_BOOT2; end
      S_BOOT2: begin op = flha_pkg::OP_W_PRO_F; state_next = S_BOOT3; end
      S_BOOT3: begin op = flha_pkg::OP_W_EPI;   state_next = S_BOOT4; end
      S_BOOT4: begin op = flha_pkg::OP_INIT;    state_next = S_G0;    end
      S_IDLE: begin
        if (s_tvalid) begin
          op         = flha_pkg::OP_ACC;
          state_next = S_DISP;
        end
      end
      S_DISP: state_next = stat.kind ? S_F0 : S_A0;
      // Allocate: zero size check, then first-fit walk
      S_A0: begin
        if (stat.req_zero) begin
          op = flha_pkg::OP_RES_ZERO; state_next = S_DONE;
        end else begin
          state_next = S_W0;
        end
      end
      S_W0: begin
        if (stat.bp_zero || stat.walk_end) begin
          state_next = S_G0;
        end else begin
          op = flha_pkg::OP_RD_BPM4; state_next = S_W1;
        end
      end
      S_W1: begin
        if (stat.fit) begin
          state_next = S_T0;
        end else begin
          op = flha_pkg::OP_RD_BP; state_next = S_W2;
        end
      end
      S_W2: begin op = flha_pkg::OP_LD_NEXT; state_next = S_W0; end
      // Heap growth
      S_G0: begin op = flha_pkg::OP_GROW_SIZE; state_next = S_G1; end
      S_G1: begin
        if (stat.grow_ovf) begin
          if (booting) begin
            booting_next = 1'b0; state_next = S_IDLE;
          end else begin
            op = flha_pkg::OP_RES_OOM; state_next = S_DONE;
          end
        end else begin
          op = flha_pkg::OP_W_BPM4_SZ; state_next = S_G2;
        end
      end
      S_G2: begin op = flha_pkg::OP_W_BPSZM8_SZ;  state_next = S_G3; end
      S_G3: begin op = flha_pkg::OP_W_BPSZM4_ONE; state_next = S_G4; end
      S_G4: begin
        op = flha_pkg::OP_SET_BRK; merge_ret_next = S_G5; state_next = S_M0;
      end
      S_G5: begin
        if (booting) begin
          booting_next = 1'b0; state_next = S_IDLE;
        end else begin
          state_next = S_T0;
        end
      end
      // Merge with free neighbors
      S_M0: begin op = flha_pkg::OP_RD_BPM8; state_next = S_M1; end
      S_M1: begin op = flha_pkg::OP_LD_PB;   state_next = S_M2; end
      S_M2: begin op = flha_pkg::OP_RD_PBM4; state_next = S_M3; end
      S_M3: begin op = flha_pkg::OP_LD_PU;   state_next = S_M4; end
      S_M4: begin op = flha_pkg::OP_RD_BPM4; state_next = S_M5; end
      S_M5: begin op = flha_pkg::OP_LD_SZ;   state_next = S_M6; end
      S_M6: begin op = flha_pkg::OP_RD_NBM4; state_next = S_M7; end
      S_M7: begin op = flha_pkg::OP_LD_NU;   state_next = S_M8; end
      S_M8: begin
        if (stat.pu && !stat.nu) begin
          op = flha_pkg::OP_X_NB; rem_ret_next = S_C1A; state_next = S_R0;
        end else if (!stat.pu && stat.nu) begin
          op = flha_pkg::OP_X_PB; rem_ret_next = S_C2A; state_next = S_R0;
        end else if (!stat.pu && !stat.nu) begin
          op = flha_pkg::OP_X_PB; rem_ret_next = S_C3A; state_next = S_R0;
        end else begin
          state_next = S_MP;
        end
      end
      S_C1A: begin op = flha_pkg::OP_RD_NBM4;     state_next = S_C1B; end
      S_C1B: begin op = flha_pkg::OP_ADD_SZ;      state_next = S_C1C; end
      S_C1C: begin op = flha_pkg::OP_W_BPM4_SZ;   state_next = S_C1D; end
      S_C1D: begin op = flha_pkg::OP_W_BPSZM8_SZ; state_next = S_MP;  end
      S_C2A: begin op = flha_pkg::OP_RD_PBM4;     state_next = S_C2B; end
      S_C2B: begin op = flha_pkg::OP_ADD_SZ;      state_next = S_C2C; end
      S_C2C: begin op = flha_pkg::OP_W_PBM4_SZ;   state_next = S_C2D; end
      S_C2D: begin op = flha_pkg::OP_W_PBSZM8_SZ; state_next = S_C2E; end
      S_C2E: begin op = flha_pkg::OP_BP_PB;       state_next = S_MP;  end
      S_C3A: begin
        op = flha_pkg::OP_X_NB; rem_ret_next = S_C3B; state_next = S_R0;
      end
      S_C3B: begin op = flha_pkg::OP_RD_PBM4; state_next = S_C3C; end
      S_C3C: begin op = flha_pkg::OP_ADD_SZ;  state_next = S_C3D; end
      S_C3D: begin op = flha_pkg::OP_RD_NBM4; state_next = S_C3E; end
      S_C3E: begin op = flha_pkg::OP_ADD_SZ;  state_next = S_C2C; end
      S_MP: begin
        op = flha_pkg::OP_X_BP; push_ret_next = merge_ret; state_next = S_P0;
      end
      // Unlink a block from the free list
      S_R0: begin op = flha_pkg::OP_RD_XP4;  state_next = S_R1; end
      S_R1: begin op = flha_pkg::OP_LD_PRED; state_next = S_R2; end
      S_R2: begin op = flha_pkg::OP_RD_X;    state_next = S_R3; end
      S_R3: begin op = flha_pkg::OP_LD_SUCC; state_next = S_R4; end
      S_R4: begin
        op = stat.pred_zero ? flha_pkg::OP_HEAD_SUCC : flha_pkg::OP_W_PRED_SUCC;
        state_next = S_R5;
      end
      S_R5: begin
        if (!stat.succ_zero) begin
          op = flha_pkg::OP_W_SUCCP4_PRED;
        end
        state_next = rem_ret;
      end
      // Push a block on the head of the free list
      S_P0: begin op = flha_pkg::OP_W_XP4_ZERO; state_next = S_P1; end
      S_P1: begin
        if (!stat.head_zero) begin
          op = flha_pkg::OP_W_HEADP4_X;
        end
        state_next = S_P2;
      end
      S_P2: begin op = flha_pkg::OP_W_X_HEAD; state_next = push_ret; end
      // Take a fitting block, splitting off the rest when large enough
      S_T0: begin op = flha_pkg::OP_RD_BPM4; state_next = S_T1; end
      S_T1: begin op = flha_pkg::OP_LD_SZ;   state_next = S_T2; end
      S_T2: begin
        op = flha_pkg::OP_X_BP; rem_ret_next = S_T3; state_next = S_R0;
      end
      S_T3: begin
        op = stat.split_ok ? flha_pkg::OP_W_BPM4_NEED1 : flha_pkg::OP_W_BPM4_SZ1;
        state_next = S_T4;
      end
      S_T4: begin
        if (stat.split_ok) begin
          op = flha_pkg::OP_W_BPNEEDM8_NEED1; state_next = S_T5;
        end else begin
          op = flha_pkg::OP_W_BPSZM8_SZ1; state_next = S_RESOK;
        end
      end
      S_T5: begin op = flha_pkg::OP_SPLIT;       state_next = S_T6; end
      S_T6: begin op = flha_pkg::OP_W_NBM4_SZ;   state_next = S_T7; end
      S_T7: begin op = flha_pkg::OP_W_NBSZM8_SZ; state_next = S_T8; end
      S_T8: begin
        op = flha_pkg::OP_X_NB; push_ret_next = S_RESOK; state_next = S_P0;
      end
      // Free: validate the block, clear its tags, then merge
      S_F0: begin
        if (!stat.free_addr_ok) begin
          op = flha_pkg::OP_RES_NONE; state_next = S_DONE;
        end else begin
          op = flha_pkg::OP_RD_BPM4; state_next = S_F1;
        end
      end
      S_F1: begin op = flha_pkg::OP_LD_SZ; state_next = S_F2; end
      S_F2: begin
        if (stat.free_blk_ok) begin
          op = flha_pkg::OP_W_BPM4_SZ; state_next = S_F3;
        end else begin
          op = flha_pkg::OP_RES_NONE; state_next = S_DONE;
        end
      end
      S_F3: begin
        op = flha_pkg::OP_W_BPSZM8_SZ; merge_ret_next = S_FN; state_next = S_M0;
      end
      S_FN:    begin op = flha_pkg::OP_RES_NONE; state_next = S_DONE; end
      S_RESOK: begin op = flha_pkg::OP_RES_OK;   state_next = S_DONE; end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          op = flha_pkg::OP_OUT_LOAD; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (op == flha_pkg::OP_OUT_LOAD) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT0;
      booting   <= 1'b1;
      m_tvalid  <= 1'b0;
      rem_ret   <= S_IDLE;
      push_ret  <= S_IDLE;
      merge_ret <= S_IDLE;
    end else begin
      state     <= state_next;
      booting   <= booting_next;
      m_tvalid  <= m_tvalid_next;
      rem_ret   <= rem_ret_next;
      push_ret  <= push_ret_next;
      merge_ret <= merge_ret_next;
    end
  end

  // The output register is only reloaded once its last item has left.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (op == flha_pkg::OP_OUT_LOAD) |-> (!m_tvalid || m_tready))
    else $error("result loaded over an undelivered item");

  // No item is taken while the heap is still being set up.
  a_boot_no_accept: assert property (@(posedge clk) disable iff (rst)
    booting |-> !(s_tvalid && s_tready))
    else $error("item accepted during heap setup");

  // An accepted item always leads to dispatch next cycle.
  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DISP))
    else $error("accepted item not dispatched");

endmodule

[tb/free_list_heap_allocator_check.sv]
// ----------------------------------------------------------------------------
// Free list heap allocator checker
// Keeps its own copy of the heap words, the free list head and the break,
// predicts the result of every accepted item and compares it with the output.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_check #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes, block_addr
  input  logic        s_tuser,   // kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // result_addr, status, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam logic [2:0] REG_CHUNK = 3'd0;

  logic [31:0] heap_mem [HEAP_WORDS];
  logic [31:0] list_head;
  logic [31:0] brk;
  logic [31:0] chunk;
  logic [17:0] result_q [$];

  // Heap word access; anything outside the array reads as zero.
  function automatic logic [31:0] hrd(logic [31:0] a);
    return ((a >> 2) < HEAP_WORDS) ? heap_mem[a >> 2] : 32'd0;
  endfunction

  function automatic void hwr(logic [31:0] a, logic [31:0] v);
    if ((a >> 2) < HEAP_WORDS) heap_mem[a >> 2] = v;
  endfunction

  function automatic logic [31:0] bsize(logic [31:0] bp);
    return hrd(bp - 4) & 32'hFFFF_FFF8;
  endfunction

  function automatic logic bused(logic [31:0] bp);
    logic [31:0] w;
    w = hrd(bp - 4);
    return w[0];
  endfunction

  function automatic void list_push(logic [31:0] bp);
    hwr(bp + 4, 0);
    if (list_head != 0) hwr(list_head + 4, bp);
    hwr(bp, list_head);
    list_head = bp;
  endfunction

  function automatic void list_unlink(logic [31:0] bp);
    logic [31:0] pred, succ;
    pred = hrd(bp + 4);
    succ = hrd(bp);
    if (pred != 0) hwr(pred, succ);
    else list_head = succ;
    if (succ != 0) hwr(succ + 4, pred);
  endfunction

  // Coalesce with free neighbors, then put the block at the list head.
  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] pb, nb, sz;
    logic pu, nu;
    pb = bp - (hrd(bp - 8) & 32'hFFFF_FFF8);
    nb = bp + bsize(bp);
    pu = bused(pb);
    nu = bused(nb);
    sz = bsize(bp);
    if (pu && !nu) begin
      list_unlink(nb);
      sz += bsize(nb);
      hwr(bp - 4, sz);
      hwr(bp + sz - 8, sz);
    end else if (!pu && nu) begin
      list_unlink(pb);
      sz += bsize(pb);
      hwr(pb - 4, sz);
      hwr(pb + sz - 8, sz);
      bp = pb;
    end else if (!pu && !nu) begin
      list_unlink(pb);
      list_unlink(nb);
      sz += bsize(pb) + bsize(nb);
      hwr(pb - 4, sz);
      hwr(pb + sz - 8, sz);
      bp = pb;
    end
    list_push(bp);
    return bp;
  endfunction

  function automatic logic [31:0] heap_grow(logic [31:0] bytes);
    logic [31:0] words, sz, bp;
    words = bytes >> 2;
    if (words[0]) words++;
    sz = words << 2;
    if (64'(brk) + 64'(sz) > 64'(HEAP_BYTES)) return 0;
    bp = brk;
    hwr(bp - 4, sz);
    hwr(bp + sz - 8, sz);
    hwr(bp + sz - 4, flha_pkg::TAG_EPILOGUE);
    brk = bp + sz;
    return coalesce(bp);
  endfunction

  function automatic logic [31:0] fit_search(logic [31:0] need);
    logic [31:0] bp;
    bp = list_head;
    for (int n = 0; bp != 0 && n < HEAP_BYTES / 16 + 1; n++) begin
      if (need <= bsize(bp) && !bused(bp)) return bp;
      bp = hrd(bp);
    end
    return 0;
  endfunction

  function automatic void place(logic [31:0] bp, logic [31:0] need);
    logic [31:0] sz, rest;
    sz = bsize(bp);
    list_unlink(bp);
    if (sz >= need + flha_pkg::MIN_BLOCK) begin
      rest = sz - need;
      hwr(bp - 4, need | 1);
      hwr(bp + need - 8, need | 1);
      hwr(bp + need - 4, rest);
      hwr(bp + sz - 8, rest);
      list_push(bp + need);
    end else begin
      hwr(bp - 4, sz | 1);
      hwr(bp + sz - 8, sz | 1);
    end
  endfunction

  // Result of one item: {status, result_addr}.
  function automatic logic [17:0] heap_predict(logic kind, logic [15:0] req,
                                               logic [15:0] addr);
    logic [31:0] need, bp, sz;
    if (!kind) begin
      if (req == 0) return {flha_pkg::ST_ZERO, 16'd0};
      need = (req <= 8) ? flha_pkg::MIN_BLOCK : 8 * ((32'(req) + 15) / 8);
      bp = fit_search(need);
      if (bp == 0) bp = heap_grow((need > chunk) ? need : chunk);
      if (bp == 0) return {flha_pkg::ST_OOM, 16'd0};
      place(bp, need);
      return {flha_pkg::ST_OK, bp[15:0]};
    end
    bp = 32'(addr);
    if (bp != 0 && bp[2:0] == 0 && bp >= 16 && bused(bp)) begin
      sz = bsize(bp);
      if (sz >= flha_pkg::MIN_BLOCK && bp + sz <= brk) begin
        hwr(bp - 4, sz);
        hwr(bp + sz - 8, sz);
        void'(coalesce(bp));
      end
    end
    return {flha_pkg::ST_OK, 16'd0};
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    logic [17:0] want;
    if (rst) begin
      // Heap setup after reset: padding, prologue, epilogue, first chunk.
      for (int i = 0; i < HEAP_WORDS; i++) heap_mem[i] = 0;
      hwr(0, 0);
      hwr(4, flha_pkg::TAG_PROLOGUE);
      hwr(8, flha_pkg::TAG_PROLOGUE);
      hwr(12, flha_pkg::TAG_EPILOGUE);
      brk = 16;
      list_head = 0;
      chunk = 32'(flha_pkg::CHUNK_RESET);
      void'(heap_grow(32'(flha_pkg::CHUNK_RESET)));
      result_q.delete();
      errors <= 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready && paddr == REG_CHUNK)
        chunk = 32'(pwdata[16:0]);
      // Accepted input items.
      if (s_tvalid && s_tready)
        result_q.push_back(heap_predict(s_tuser, s_tdata[15:0], s_tdata[31:16]));
      // Accepted results, compared with the oldest expectation.
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: addr %0d status %0d", $time,
                   m_tdata[15:0], m_tdata[17:16]);
          errors <= errors + 1;
        end else begin
          want = result_q.pop_front();
          if (m_tdata[15:0] !== want[15:0] || m_tdata[17:16] !== want[17:16]
              || m_tdata[23:18] !== 6'd0) begin
            $display("%0t: mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                     $time, want[15:0], want[17:16], m_tdata[15:0], m_tdata[17:16]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[tb/free_list_heap_allocator_test.sv]
// ----------------------------------------------------------------------------
// Free list heap allocator testbench
// Drives allocate and free items with random gaps and back pressure, changes
// the chunk size between phases and lets the checker judge every result.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_test;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam logic [2:0] REG_CHUNK = 3'd0;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;   // request_bytes[15:0], block_addr[31:16]
  logic        s_tuser = 0;   // kind
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;       // result_addr[15:0], status[17:16], zero fill
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  bit          gaps_on = 1;

  logic        sent_kind [$];
  logic [15:0] live [$];

  free_list_heap_allocator dut (.*);

  free_list_heap_allocator_check chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver stalls.
  always @(posedge clk) m_tready <= !gaps_on || $urandom_range(99) >= 36;

  // Track the blocks that are currently allocated.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sent_kind.push_back(s_tuser);
    if (!rst && m_tvalid && m_tready && sent_kind.size() > 0)
      if (sent_kind.pop_front() == KIND_ALLOC && m_tdata[17:16] == flha_pkg::ST_OK)
        live.push_back(m_tdata[15:0]);
  end

  task automatic send(logic kind, logic [15:0] req, logic [15:0] addr);
    if (gaps_on && $urandom_range(99) < 36) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {addr, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic alloc(logic [15:0] req);
    send(KIND_ALLOC, req, 16'($urandom));
  endtask

  task automatic release_blk(logic [15:0] addr);
    send(KIND_FREE, 16'($urandom), addr);
  endtask

  // Stop sending and wait until every result is back and the block is idle.
  task automatic drain();
    @(posedge clk);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0 || sent_kind.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_chunk(logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= REG_CHUNK;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Random mix of allocates and frees, with a few zero-size allocates and malformed frees.
  task automatic random_phase(int count);
    int roll, k;
    logic [15:0] req;
    for (int n = 0; n < count; n++) begin
      gaps_on = !(n >= count / 3 && n < count / 3 + 60);
      roll = $urandom_range(99);
      if (roll < 2) begin
        alloc(0);
      end else if (roll < 6) begin
        case ($urandom_range(2))
          0: release_blk(0);
          1: release_blk(16'($urandom) | 16'd1);
          default: release_blk(16'($urandom_range(1, 15)));
        endcase
      end else if (live.size() > 0 && (roll < 50 || live.size() > 60)) begin
        k = $urandom_range(live.size() - 1);
        release_blk(live[k]);
        live.delete(k);
      end else begin
        roll = $urandom_range(99);
        if (roll < 80) req = 16'($urandom_range(1, 200));
        else if (roll < 95) req = 16'($urandom_range(201, 4000));
        else req = 16'($urandom);
        alloc(req);
      end
    end
    gaps_on = 1;
  endtask

  initial begin
    logic [15:0] a, b, c, d;
    repeat (10) @(posedge clk);
    rst <= 0;
    // Let the heap setup finish before touching the chunk register.
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    // Directed: size extremes, zero size, out of memory, malformed frees.
    write_chunk(16);
    alloc(0);
    alloc(1);
    alloc(8);
    alloc(9);
    alloc(16'hFFFF);
    release_blk(0);
    release_blk(16'd8);
    release_blk(16'd3);
    release_blk(16'hFFFF);
    alloc(24);
    alloc(24);
    alloc(24);
    alloc(24);
    drain();
    // Coalescing: neither, next, previous and both neighbors free.
    d = live.pop_back();
    c = live.pop_back();
    b = live.pop_back();
    a = live.pop_back();
    release_blk(b);
    release_blk(c);
    release_blk(a);
    release_blk(d);
    drain();

    // Random phases across chunk sizes, extremes included.
    write_chunk(65536);
    random_phase(250);
    drain();
    write_chunk(16);
    random_phase(300);
    drain();
    write_chunk($urandom_range(16, 65536));
    random_phase(250);
    drain();
    write_chunk(4096);
    random_phase(480);
    drain();

    if (errors == 0) $display("free_list_heap_allocator_test: PASS");
    else $display("free_list_heap_allocator_test: FAIL");
    $finish;
  end

  initial begin
    #50000000;
    $display("free_list_heap_allocator_test: FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/flha_pkg.sv
design/flha_dpath.sv
design/flha_ctrl.sv
design/free_list_heap_allocator.sv
tb/free_list_heap_allocator_check.sv
tb/free_list_heap_allocator_test.sv
